// ===== rtl/core/loh_pkg.sv =====
`default_nettype none
package loh_pkg;

  localparam int DEF_MAX_TRUE_REGIONS = 64;
  localparam int DEF_MAX_PRED_REGIONS = 64;
  localparam int DEF_COUNT_BITS       = 32;

  localparam int LABEL_W     = 16;
  localparam int CFG_W       = 7;
  localparam int CFG_INDEX_W = 1;
  localparam int OUT_COUNT_W = 32;
  localparam int STATUS_W    = 2;

  localparam logic [CFG_W-1:0] TRUE_COUNT_RESET = 7'd64;
  localparam logic [CFG_W-1:0] PRED_COUNT_RESET = 7'd64;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_BACKGROUND = 2'd1,
    ST_TRUE_RANGE = 2'd2,
    ST_PRED_RANGE = 2'd3
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TRUE_COUNT = 1'b0,
    REG_PRED_COUNT = 1'b1
  } reg_index_t;

  typedef enum logic {
    PH_CLEAR = 1'b0,
    PH_RUN   = 1'b1
  } phase_t;

  // classified item handed from the label check to the update stage
  typedef struct packed {
    logic    is_read;
    status_t status;
  } item_t;

endpackage
`default_nettype wire

// ===== rtl/core/loh_classify.sv =====
`default_nettype none
module loh_classify #(
  parameter int MAX_TRUE_REGIONS = loh_pkg::DEF_MAX_TRUE_REGIONS,
  parameter int MAX_PRED_REGIONS = loh_pkg::DEF_MAX_PRED_REGIONS,
  parameter int ADDR_W           = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [loh_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [loh_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic                            kind,
  input  wire logic [loh_pkg::LABEL_W-1:0]     true_label,
  input  wire logic [loh_pkg::LABEL_W-1:0]     pred_label,
  output loh_pkg::item_t                       item,
  output logic [ADDR_W-1:0]                    addr
);

  localparam int TRUE_IDX_W = (MAX_TRUE_REGIONS > 1) ? $clog2(MAX_TRUE_REGIONS) : 1;
  localparam int PRED_IDX_W = (MAX_PRED_REGIONS > 1) ? $clog2(MAX_PRED_REGIONS) : 1;
  localparam int CMP_W      = loh_pkg::LABEL_W + 1;

  logic [loh_pkg::CFG_W-1:0] true_count;
  logic [loh_pkg::CFG_W-1:0] pred_count;
  logic [CMP_W-1:0]          true_limit;
  logic [CMP_W-1:0]          pred_limit;
  logic [TRUE_IDX_W-1:0]     true_idx;
  logic [PRED_IDX_W-1:0]     pred_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      true_count <= loh_pkg::TRUE_COUNT_RESET;
      pred_count <= loh_pkg::PRED_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (loh_pkg::reg_index_t'(cfg_index))
        loh_pkg::REG_TRUE_COUNT: true_count <= cfg_data;
        loh_pkg::REG_PRED_COUNT: pred_count <= cfg_data;
      endcase
    end
  end

  // effective counts saturate at the matrix dimensions
  always_comb begin
    true_limit = (CMP_W'(true_count) > CMP_W'(MAX_TRUE_REGIONS)) ?
                 CMP_W'(MAX_TRUE_REGIONS) : CMP_W'(true_count);
    pred_limit = (CMP_W'(pred_count) > CMP_W'(MAX_PRED_REGIONS)) ?
                 CMP_W'(MAX_PRED_REGIONS) : CMP_W'(pred_count);
  end

  always_comb begin
    item.is_read = kind;
    priority if (true_label == '0 || pred_label == '0) begin
      item.status = loh_pkg::ST_BACKGROUND;
    end else if (CMP_W'(true_label) > true_limit) begin
      item.status = loh_pkg::ST_TRUE_RANGE;
    end else if (CMP_W'(pred_label) > pred_limit) begin
      item.status = loh_pkg::ST_PRED_RANGE;
    end else begin
      item.status = loh_pkg::ST_OK;
    end
  end

  // row-major cell address, meaningful only for in-range labels
  always_comb begin
    true_idx = TRUE_IDX_W'(true_label - loh_pkg::LABEL_W'(1));
    pred_idx = PRED_IDX_W'(pred_label - loh_pkg::LABEL_W'(1));
    addr     = ADDR_W'(ADDR_W'(true_idx) * ADDR_W'(MAX_PRED_REGIONS)) + ADDR_W'(pred_idx);
  end

endmodule
`default_nettype wire

// ===== rtl/core/loh_ram.sv =====
`default_nettype none
module loh_ram #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/loh_update.sv =====
`default_nettype none
module loh_update #(
  parameter int CELL_TOTAL = 4096,
  parameter int ADDR_W     = 12,
  parameter int COUNT_BITS = loh_pkg::DEF_COUNT_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire loh_pkg::item_t                  in_item,
  input  wire logic [ADDR_W-1:0]               in_addr,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output loh_pkg::status_t                     out_status,
  output logic [loh_pkg::OUT_COUNT_W-1:0]      out_count
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_TOTAL - 1);

  loh_pkg::phase_t   phase;
  loh_pkg::phase_t   phase_next;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] clr_addr_next;

  logic              s1_valid;
  logic              s1_read;
  loh_pkg::status_t  s1_status;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_fwd;
  logic [COUNT_BITS-1:0] s1_fwd_data;

  logic                  s1_advance;
  logic                  s1_hit;
  logic                  s1_wr_en;
  logic [COUNT_BITS-1:0] s1_old;
  logic [COUNT_BITS-1:0] s1_wr_data;
  logic [63:0]           s1_old_ext;
  logic [loh_pkg::OUT_COUNT_W-1:0] s1_count;
  logic                  accept;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_wr_addr;
  logic [COUNT_BITS-1:0] ram_wr_data;
  logic                  ram_re;
  logic [COUNT_BITS-1:0] ram_rd_data;

  // clearing sweep after reset, then normal operation
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= loh_pkg::PH_CLEAR;
      clr_addr <= '0;
    end else begin
      phase    <= phase_next;
      clr_addr <= clr_addr_next;
    end
  end

  always_comb begin
    phase_next    = phase;
    clr_addr_next = clr_addr;
    unique case (phase)
      loh_pkg::PH_CLEAR: begin
        clr_addr_next = clr_addr + ADDR_W'(1);
        if (clr_addr == LAST_ADDR) begin
          phase_next    = loh_pkg::PH_RUN;
          clr_addr_next = '0;
        end
      end
      loh_pkg::PH_RUN: begin
        phase_next = loh_pkg::PH_RUN;
      end
    endcase
  end

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = (phase == loh_pkg::PH_RUN) && (!s1_valid || s1_advance);
  assign accept     = in_valid && in_ready;

  // the beat leaving stage 1 writes back at the edge that reads the next one
  assign s1_old     = s1_fwd ? s1_fwd_data : ram_rd_data;
  assign s1_hit     = (s1_status == loh_pkg::ST_OK);
  assign s1_wr_en   = s1_advance && s1_hit;
  assign s1_wr_data = s1_read ? '0 : ((&s1_old) ? s1_old : s1_old + COUNT_BITS'(1));
  assign s1_old_ext = 64'(s1_old);
  assign s1_count   = (s1_read && s1_hit) ?
                      ((|s1_old_ext[63:32]) ? '1 : s1_old_ext[31:0]) : '0;

  always_comb begin
    if (phase == loh_pkg::PH_CLEAR) begin
      ram_we      = 1'b1;
      ram_wr_addr = clr_addr;
      ram_wr_data = '0;
    end else begin
      ram_we      = s1_wr_en;
      ram_wr_addr = s1_addr;
      ram_wr_data = s1_wr_data;
    end
  end

  assign ram_re = accept && (in_item.status == loh_pkg::ST_OK);

  loh_ram #(
    .DEPTH  (CELL_TOTAL),
    .ADDR_W (ADDR_W),
    .DATA_W (COUNT_BITS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .re      (ram_re),
    .rd_addr (in_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_read     <= in_item.is_read;
      s1_status   <= in_item.status;
      s1_addr     <= in_addr;
      s1_fwd      <= s1_wr_en && (s1_addr == in_addr);
      s1_fwd_data <= s1_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_status <= s1_status;
      out_count  <= s1_count;
    end
  end

  a_no_beats_while_clearing: assert property (@(posedge clk) disable iff (rst)
    phase == loh_pkg::PH_CLEAR |-> !s1_valid && !out_valid)
    else $error("beat in flight during clearing sweep");

  a_rejected_never_writes: assert property (@(posedge clk) disable iff (rst)
    phase == loh_pkg::PH_RUN && s1_valid && !s1_hit |-> !ram_we)
    else $error("rejected label pair wrote the counter store");

  a_count_zero_unless_read: assert property (@(posedge clk) disable iff (rst)
    s1_advance && (!s1_read || !s1_hit) |=> out_count == '0)
    else $error("nonzero count on a beat that read no cell");

  a_fwd_from_writeback: assert property (@(posedge clk) disable iff (rst)
    accept && !s1_wr_en |=> !s1_fwd)
    else $error("forwarding set without a write-back");

endmodule
`default_nettype wire

// ===== rtl/core/label_overlap_histogram.sv =====
`default_nettype none
// channel  dir  tdata                             tuser
// s        in   [15:0] true_label, [31:16] pred   [0] kind
// m        out  [31:0] cell_count                 [1:0] status
// cfg      in   cfg_index 0 true_region_count, 1 pred_region_count; cfg_data [6:0]
//
// one beat per cycle sustained while m is ready: the counter memory is read
// at accept and the modified count written back as the beat leaves stage 1,
// with same-cell forwarding between consecutive beats. after reset a sweep
// zeroes the store, one cell per cycle, s_tready low; it covers all
// MAX_TRUE_REGIONS * MAX_PRED_REGIONS cells (4096 by default).
// a stalled m side holds the output register and then stage 1 and s_tready.
module label_overlap_histogram #(
  parameter int MAX_TRUE_REGIONS = loh_pkg::DEF_MAX_TRUE_REGIONS,
  parameter int MAX_PRED_REGIONS = loh_pkg::DEF_MAX_PRED_REGIONS,
  parameter int COUNT_BITS       = loh_pkg::DEF_COUNT_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [31:0]                     s_tdata,   // true_label, pred_label
  input  wire logic [0:0]                      s_tuser,   // kind
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [31:0]                          m_tdata,   // cell_count
  output logic [1:0]                           m_tuser,   // status
  input  wire logic                            cfg_we,
  input  wire logic [loh_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [loh_pkg::CFG_W-1:0]       cfg_data
);

  localparam int CELL_TOTAL = MAX_TRUE_REGIONS * MAX_PRED_REGIONS;
  localparam int ADDR_W     = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;

  loh_pkg::item_t   item;
  logic [ADDR_W-1:0] addr;
  loh_pkg::status_t out_status;

  loh_classify #(
    .MAX_TRUE_REGIONS (MAX_TRUE_REGIONS),
    .MAX_PRED_REGIONS (MAX_PRED_REGIONS),
    .ADDR_W           (ADDR_W)
  ) u_classify (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .kind       (s_tuser[0]),
    .true_label (s_tdata[15:0]),
    .pred_label (s_tdata[31:16]),
    .item       (item),
    .addr       (addr)
  );

  loh_update #(
    .CELL_TOTAL (CELL_TOTAL),
    .ADDR_W     (ADDR_W),
    .COUNT_BITS (COUNT_BITS)
  ) u_update (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (item),
    .in_addr    (addr),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_count  (m_tdata)
  );

  assign m_tuser = out_status;

endmodule
`default_nettype wire
